[rtl/assert_macros.svh]
// Assertion macros used by the probe response classifier.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

[rtl/ppr_pkg.sv]
package ppr_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_ERROR = 2'd3;

    // Verdict codes.
    localparam logic [1:0] V_OPEN     = 2'd0;
    localparam logic [1:0] V_CLOSED   = 2'd1;
    localparam logic [1:0] V_FILTERED = 2'd2;
    localparam logic [1:0] V_ERROR    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PROBE_IS_UDP      = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_MS        = 2'd1;
    localparam logic [1:0] CFG_PROBE_SOURCE_PORT = 2'd2;

    localparam logic        RESET_PROBE_IS_UDP      = 1'b0;
    localparam logic [15:0] RESET_TIMEOUT_MS        = 16'd3000;
    localparam logic [15:0] RESET_PROBE_SOURCE_PORT = 16'd54321;

    // IPv4 protocol numbers and TCP flag bits.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] FLAG_SYN   = 8'h02;
    localparam logic [7:0] FLAG_RST   = 8'h04;
    localparam logic [7:0] FLAG_ACK   = 8'h10;

    // ICMP destination unreachable, port unreachable.
    localparam logic [15:0] ICMP_PORT_UNREACH = 16'h0303;

    localparam logic [15:0] POSITION_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] probe_port;
    } in_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       answered;
    } out_t;

    // Fields latched from one frame. The first two transport bytes serve
    // both as the TCP/UDP source port and as the ICMP type and code.
    typedef struct packed {
        logic [3:0]  ip_header_words;
        logic [7:0]  ip_protocol;
        logic [15:0] transport_word;
        logic [7:0]  tcp_flag_bits;
        logic [3:0]  inner_header_words;
        logic [7:0]  inner_protocol;
        logic [31:0] inner_ports;
    } frame_t;

    typedef struct packed {
        logic take;
        logic clear;
    } parse_ctrl_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] verdict;
    } judge_t;

endpackage

[rtl/ppr_frame_parser.sv]
module ppr_frame_parser #(
    parameter int LINK_HEADER_BYTES = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ppr_pkg::parse_ctrl_t ctrl,
    input  logic [7:0]          data_byte,
    output ppr_pkg::frame_t     taken
);

    localparam logic [15:0] IP_OFS = 16'(LINK_HEADER_BYTES);

    ppr_pkg::frame_t fields_reg;
    ppr_pkg::frame_t fields_next;
    logic [15:0]     position_reg;
    logic [15:0]     position_next;
    logic [15:0]     tr_ofs;
    logic [15:0]     em_ofs;
    logic [15:0]     eu_ofs;
    logic [15:0]     p;

    // Offsets follow the header lengths latched so far, including any length
    // latched from the current byte.
    always_comb
    begin
        p     = position_reg;
        taken = fields_reg;
        if (p == IP_OFS)
        begin
            taken.ip_header_words = data_byte[3:0];
        end
        if (p == IP_OFS + 16'd9)
        begin
            taken.ip_protocol = data_byte;
        end
        tr_ofs = IP_OFS + {10'd0, taken.ip_header_words, 2'b00};
        if (p == tr_ofs)
        begin
            taken.transport_word[15:8] = data_byte;
        end
        if (p == tr_ofs + 16'd1)
        begin
            taken.transport_word[7:0] = data_byte;
        end
        if (p == tr_ofs + 16'd13)
        begin
            taken.tcp_flag_bits = data_byte;
        end
        em_ofs = tr_ofs + 16'd8;
        if (p == em_ofs)
        begin
            taken.inner_header_words = data_byte[3:0];
        end
        if (p == em_ofs + 16'd9)
        begin
            taken.inner_protocol = data_byte;
        end
        eu_ofs = em_ofs + {10'd0, taken.inner_header_words, 2'b00};
        if (p == eu_ofs)
        begin
            taken.inner_ports[31:24] = data_byte;
        end
        if (p == eu_ofs + 16'd1)
        begin
            taken.inner_ports[23:16] = data_byte;
        end
        if (p == eu_ofs + 16'd2)
        begin
            taken.inner_ports[15:8] = data_byte;
        end
        if (p == eu_ofs + 16'd3)
        begin
            taken.inner_ports[7:0] = data_byte;
        end
    end

    always_comb
    begin
        fields_next   = fields_reg;
        position_next = position_reg;
        if (ctrl.clear)
        begin
            fields_next   = '0;
            position_next = '0;
        end
        else if (ctrl.take)
        begin
            fields_next = taken;
            if (position_reg != ppr_pkg::POSITION_MAX)
            begin
                position_next = position_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg   <= '0;
            position_reg <= '0;
        end
        else
        begin
            fields_reg   <= fields_next;
            position_reg <= position_next;
        end
    end

endmodule

[rtl/ppr_judge.sv]
module ppr_judge (
    input  ppr_pkg::frame_t frame,
    input  logic            probe_is_udp,
    input  logic [15:0]     target_port,
    input  logic [15:0]     probe_source_port,
    output ppr_pkg::judge_t result
);

    logic port_match;
    logic syn_ack;

    assign port_match = (frame.transport_word == target_port);
    assign syn_ack    = ((frame.tcp_flag_bits & (ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK))
                         == (ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK));

    always_comb
    begin
        result = '{hit: 1'b0, verdict: ppr_pkg::V_OPEN};
        if (!probe_is_udp)
        begin
            if (frame.ip_protocol == ppr_pkg::PROTO_TCP && port_match)
            begin
                result.hit = 1'b1;
                priority if (syn_ack)
                begin
                    result.verdict = ppr_pkg::V_OPEN;
                end
                else if ((frame.tcp_flag_bits & ppr_pkg::FLAG_RST) != 8'd0)
                begin
                    result.verdict = ppr_pkg::V_CLOSED;
                end
                else
                begin
                    result.verdict = ppr_pkg::V_FILTERED;
                end
            end
        end
        else if (frame.ip_protocol == ppr_pkg::PROTO_UDP && port_match)
        begin
            result.hit     = 1'b1;
            result.verdict = ppr_pkg::V_OPEN;
        end
        else if (frame.ip_protocol == ppr_pkg::PROTO_ICMP
                 && frame.transport_word == ppr_pkg::ICMP_PORT_UNREACH
                 && frame.inner_protocol == ppr_pkg::PROTO_UDP
                 && frame.inner_ports[31:16] == probe_source_port
                 && frame.inner_ports[15:0] == target_port)
        begin
            result.hit     = 1'b1;
            result.verdict = ppr_pkg::V_CLOSED;
        end
    end

endmodule

[rtl/port_probe_response_classifier.sv]
// Port probe response classifier. A start request arms a wait for the reply
// to one probe sent to a given destination port; captured Ethernet/IPv4 frames
// then arrive one byte per request, and at a frame's last byte the block gives
// a verdict (open, closed or filtered, answered set) if the frame is a TCP
// reply from the probed port, a UDP reply from it, or an ICMP port-unreachable
// quoting our UDP probe. Millisecond tick requests give filtered once the
// configured timeout is reached, and a capture error request gives error; both
// with answered clear. Requests that decide nothing give no result. The block
// takes one request every cycle unless a stalled output register holds it
// back: each request is held in an input register, handled in one pass of
// short logic (field latching, offset compares and the verdict decision) and
// its result, if any, lands in an output register when the held request is
// handled. A stalled output register holds back the input register only when
// both are full. Configuration is written through a plain write port and should
// only change while no request is in flight.
`include "assert_macros.svh"

module port_probe_response_classifier #(
    parameter int LINK_HEADER_BYTES = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ppr_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ppr_pkg::out_t out_data,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    // Configuration registers.
    logic        probe_is_udp_reg;
    logic [15:0] timeout_ms_reg;
    logic [15:0] probe_source_port_reg;

    // Input register.
    logic         in_valid_reg;
    logic         in_valid_next;
    ppr_pkg::in_t in_data_reg;

    // Probe state.
    logic        waiting_reg;
    logic        waiting_next;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic [15:0] target_port_reg;
    logic [15:0] target_port_next;

    // Output register.
    logic          out_valid_reg;
    logic          out_valid_next;
    ppr_pkg::out_t out_data_reg;
    ppr_pkg::out_t res;
    logic          res_fire;

    logic                 advance;
    logic [15:0]          elapsed_inc;
    ppr_pkg::parse_ctrl_t parse_ctrl;
    ppr_pkg::frame_t      frame_taken;
    ppr_pkg::judge_t      judged;

    // The held request is handled whenever the output register can take a result.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign in_valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_is_udp_reg      <= ppr_pkg::RESET_PROBE_IS_UDP;
            timeout_ms_reg        <= ppr_pkg::RESET_TIMEOUT_MS;
            probe_source_port_reg <= ppr_pkg::RESET_PROBE_SOURCE_PORT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ppr_pkg::CFG_PROBE_IS_UDP:      probe_is_udp_reg      <= cfg_data[0];
                ppr_pkg::CFG_TIMEOUT_MS:        timeout_ms_reg        <= cfg_data;
                ppr_pkg::CFG_PROBE_SOURCE_PORT: probe_source_port_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Frame bytes are parsed whether or not a probe is armed; a start or a
    // frame's last byte wipes the latched fields.
    assign parse_ctrl = '{take:  advance && (in_data_reg.op == ppr_pkg::OP_BYTE),
                          clear: advance && ((in_data_reg.op == ppr_pkg::OP_START)
                                             || (in_data_reg.op == ppr_pkg::OP_BYTE
                                                 && in_data_reg.last_byte))};

    ppr_frame_parser #(
        .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (parse_ctrl),
        .data_byte (in_data_reg.data_byte),
        .taken     (frame_taken)
    );

    ppr_judge u_judge (
        .frame             (frame_taken),
        .probe_is_udp      (probe_is_udp_reg),
        .target_port       (target_port_reg),
        .probe_source_port (probe_source_port_reg),
        .result            (judged)
    );

    // The elapsed count saturates rather than wrapping.
    assign elapsed_inc = (elapsed_reg != 16'hFFFF) ? elapsed_reg + 16'd1 : elapsed_reg;

    always_comb
    begin
        waiting_next     = waiting_reg;
        elapsed_next     = elapsed_reg;
        target_port_next = target_port_reg;
        res_fire         = 1'b0;
        res              = '{verdict: ppr_pkg::V_OPEN, answered: 1'b0};
        if (advance)
        begin
            unique case (in_data_reg.op)
                ppr_pkg::OP_START:
                begin
                    // A start while armed simply re-arms with the new port.
                    waiting_next     = 1'b1;
                    target_port_next = in_data_reg.probe_port;
                    elapsed_next     = '0;
                end
                ppr_pkg::OP_BYTE:
                begin
                    if (in_data_reg.last_byte && waiting_reg && judged.hit)
                    begin
                        waiting_next = 1'b0;
                        res_fire     = 1'b1;
                        res          = '{verdict: judged.verdict, answered: 1'b1};
                    end
                end
                ppr_pkg::OP_TICK:
                begin
                    if (waiting_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_ms_reg)
                        begin
                            waiting_next = 1'b0;
                            res_fire     = 1'b1;
                            res          = '{verdict: ppr_pkg::V_FILTERED, answered: 1'b0};
                        end
                    end
                end
                ppr_pkg::OP_ERROR:
                begin
                    if (waiting_reg)
                    begin
                        waiting_next = 1'b0;
                        res_fire     = 1'b1;
                        res          = '{verdict: ppr_pkg::V_ERROR, answered: 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg     <= 1'b0;
            elapsed_reg     <= '0;
            target_port_reg <= '0;
        end
        else
        begin
            waiting_reg     <= waiting_next;
            elapsed_reg     <= elapsed_next;
            target_port_reg <= target_port_next;
        end
    end

    assign out_valid_next = (advance && res_fire) ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_fire)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A result always ends the armed wait.
    `PPR_ASSERT_NEXT(a_result_disarms, advance && res_fire, !waiting_reg)
    // A handled start arms the wait with a fresh timeout count.
    `PPR_ASSERT_NEXT(a_start_arms, advance && in_data_reg.op == ppr_pkg::OP_START,
                     waiting_reg && elapsed_reg == 16'd0)
    // Open and closed verdicts only ever come from a matching reply.
    `PPR_ASSERT_SAME(a_unanswered_kind, out_valid_reg && !out_data_reg.answered,
                     out_data_reg.verdict == ppr_pkg::V_FILTERED
                     || out_data_reg.verdict == ppr_pkg::V_ERROR)
    // Nothing is decided unless a probe was armed.
    `PPR_ASSERT_SAME(a_fire_needs_wait, advance && res_fire, waiting_reg)

endmodule

[dv/port_probe_response_classifier_tb.sv]
`timescale 1ns / 100ps

module port_probe_response_classifier_tb;

    // Ethernet header length used by both the block and the local predictor.
    localparam int LINK_BYTES = 14;
    // A result passes the input and the output register after its request is accepted; this margin
    // covers the pipeline after the last expected verdict has arrived.
    localparam int DRAIN_CYCLES = 8;
    // Length of the deliberate receiver hold-off used to back the block up.
    localparam int LONG_STALL_CYCLES = 200;
    // Rough number of requests to issue over the whole run.
    localparam int REQUEST_BUDGET = 1750;
    // Keep the printed log short even if everything goes wrong.
    localparam int PRINT_LIMIT = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic          in_valid = 1'b0;
    logic          in_ready;
    ppr_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    ppr_pkg::out_t out_data;
    logic          cfg_write = 1'b0;
    logic [1:0]    cfg_index = ppr_pkg::CFG_PROBE_IS_UDP;
    logic [15:0]   cfg_data = '0;

    // Requests waiting to be offered by the driver, filled by the stimulus.
    ppr_pkg::in_t  pending_requests[$];
    // Verdicts that the predictor expects, oldest first.
    ppr_pkg::out_t expected_verdicts[$];
    // Scratch buffer in which one captured frame is assembled.
    logic [7:0] frame_buf[$];

    int requests_queued = 0;
    int requests_accepted = 0;
    int mismatch_count = 0;

    // Idling controls, set per phase by the stimulus process.
    bit source_idling = 1'b0;
    bit sink_idling = 1'b0;
    int long_stalls_asked = 0;
    int long_stalls_served;
    int sink_hold;
    int send_gap;

    // Local copy of the configuration registers.
    logic        cfg_udp_probe;
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_src_port;

    // Predicted state of the classifier.
    logic        armed = 1'b0;
    logic [15:0] ticks_elapsed = '0;
    logic [15:0] target_port = '0;
    logic [15:0] frame_pos = '0;
    logic [3:0]  ip_words = '0;
    logic [7:0]  ip_proto = '0;
    logic [15:0] transport_word = '0;
    logic [7:0]  tcp_flags = '0;
    logic [3:0]  inner_words = '0;
    logic [7:0]  inner_proto = '0;
    logic [31:0] inner_ports = '0;

    port_probe_response_classifier #(
        .LINK_HEADER_BYTES(LINK_BYTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Every last byte and every start request forget the frame in progress.
    function automatic void clear_frame_fields();
        frame_pos = '0;
        ip_words = '0;
        ip_proto = '0;
        transport_word = '0;
        tcp_flags = '0;
        inner_words = '0;
        inner_proto = '0;
        inner_ports = '0;
    endfunction

    // Latches one frame byte into every field whose offset it hits. Offsets
    // follow the header lengths latched so far, including one taken from
    // this very byte, so malformed lengths may make fields overlap.
    function automatic void take_frame_byte(input logic [7:0] b);
        int pos;
        int tr;
        int em;
        int eu;
        pos = int'(frame_pos);
        if (pos == LINK_BYTES)
            ip_words = b[3:0];
        if (pos == LINK_BYTES + 9)
            ip_proto = b;
        tr = LINK_BYTES + 4 * int'(ip_words);
        if (pos == tr)
            transport_word[15:8] = b;
        if (pos == tr + 1)
            transport_word[7:0] = b;
        if (pos == tr + 13)
            tcp_flags = b;
        em = tr + 8;
        if (pos == em)
            inner_words = b[3:0];
        if (pos == em + 9)
            inner_proto = b;
        eu = em + 4 * int'(inner_words);
        if (pos == eu)
            inner_ports[31:24] = b;
        if (pos == eu + 1)
            inner_ports[23:16] = b;
        if (pos == eu + 2)
            inner_ports[15:8] = b;
        if (pos == eu + 3)
            inner_ports[7:0] = b;
        if (frame_pos != ppr_pkg::POSITION_MAX)
            frame_pos = frame_pos + 16'd1;
    endfunction

    // Decides whether the completed frame answers the armed probe.
    function automatic logic reply_verdict(output logic [1:0] v);
        v = ppr_pkg::V_OPEN;
        if (!cfg_udp_probe)
        begin
            if (ip_proto == ppr_pkg::PROTO_TCP && transport_word == target_port)
            begin
                if ((tcp_flags & (ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK))
                    == (ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK))
                    v = ppr_pkg::V_OPEN;
                else if ((tcp_flags & ppr_pkg::FLAG_RST) != 8'd0)
                    v = ppr_pkg::V_CLOSED;
                else
                    v = ppr_pkg::V_FILTERED;
                return 1'b1;
            end
            return 1'b0;
        end
        if (ip_proto == ppr_pkg::PROTO_UDP && transport_word == target_port)
        begin
            v = ppr_pkg::V_OPEN;
            return 1'b1;
        end
        // ICMP port unreachable quoting our own UDP probe.
        if (ip_proto == ppr_pkg::PROTO_ICMP && transport_word == ppr_pkg::ICMP_PORT_UNREACH &&
            inner_proto == ppr_pkg::PROTO_UDP && inner_ports[31:16] == cfg_src_port &&
            inner_ports[15:0] == target_port)
        begin
            v = ppr_pkg::V_CLOSED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one accepted request to the predicted state and queues the
    // verdict it gives, if any.
    function automatic void classify_request(input ppr_pkg::in_t req);
        logic          hit;
        logic [1:0]    v;
        ppr_pkg::out_t res;
        hit = 1'b0;
        v = ppr_pkg::V_OPEN;
        res = '0;
        case (req.op)
            ppr_pkg::OP_START:
            begin
                armed = 1'b1;
                target_port = req.probe_port;
                ticks_elapsed = '0;
                clear_frame_fields();
            end
            ppr_pkg::OP_BYTE:
            begin
                take_frame_byte(req.data_byte);
                if (req.last_byte)
                begin
                    if (armed)
                        hit = reply_verdict(v);
                    clear_frame_fields();
                end
                if (hit)
                begin
                    armed = 1'b0;
                    res.verdict = v;
                    res.answered = 1'b1;
                    expected_verdicts.push_back(res);
                end
            end
            ppr_pkg::OP_TICK:
            begin
                if (armed)
                begin
                    if (ticks_elapsed != 16'hFFFF)
                        ticks_elapsed = ticks_elapsed + 16'd1;
                    if (ticks_elapsed >= cfg_timeout)
                    begin
                        armed = 1'b0;
                        res.verdict = ppr_pkg::V_FILTERED;
                        res.answered = 1'b0;
                        expected_verdicts.push_back(res);
                    end
                end
            end
            ppr_pkg::OP_ERROR:
            begin
                if (armed)
                begin
                    armed = 1'b0;
                    res.verdict = ppr_pkg::V_ERROR;
                    res.answered = 1'b0;
                    expected_verdicts.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The driver offers the next pending request once the current one has
    // been taken, holding valid and payload steady while the block stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_requests.pop_front();
                send_gap <= source_idling ? pick_gap() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver normally takes results at once, stalls at random when
    // asked to, and serves each long hold-off requested by the stimulus.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_hold <= 0;
            long_stalls_served <= 0;
        end
        else if (long_stalls_served != long_stalls_asked)
        begin
            out_ready <= 1'b0;
            sink_hold <= LONG_STALL_CYCLES;
            long_stalls_served <= long_stalls_served + 1;
        end
        else if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else if (sink_idling && $urandom_range(0, 99) < 25)
        begin
            out_ready <= 1'b0;
            sink_hold <= pick_gap();
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // The monitor samples both handshakes at the clock edge: accepted
    // requests feed the predictor, accepted results are checked against the
    // oldest expected verdict.
    always @(posedge clk)
    begin
        ppr_pkg::out_t awaited;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                classify_request(in_data);
                requests_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, verdict %0d answered %0d",
                                              out_data.verdict, out_data.answered));
                end
                else
                begin
                    awaited = expected_verdicts.pop_front();
                    if (out_data.verdict !== awaited.verdict)
                        report_mismatch($sformatf("verdict %0d, expected %0d",
                                                  out_data.verdict, awaited.verdict));
                    if (out_data.answered !== awaited.answered)
                        report_mismatch($sformatf("answered %0d, expected %0d",
                                                  out_data.answered, awaited.answered));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_request(input logic [1:0] op, input logic [7:0] data,
                                 input logic last, input logic [15:0] port);
        ppr_pkg::in_t req;
        req.op = op;
        req.data_byte = data;
        req.last_byte = last;
        req.probe_port = port;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // Fields that an operation does not use are filled at random.
    task automatic queue_start(input logic [15:0] port);
        queue_request(ppr_pkg::OP_START, 8'($urandom), 1'($urandom), port);
    endtask

    task automatic queue_tick();
        queue_request(ppr_pkg::OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic queue_capture_error();
        queue_request(ppr_pkg::OP_ERROR, 8'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // Waits for every queued request to be taken and every verdict to come
    // back, then lets the pipeline settle before the configuration changes.
    task automatic wait_idle();
        while (requests_accepted != requests_queued || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            ppr_pkg::CFG_PROBE_IS_UDP:      cfg_udp_probe = value[0];
            ppr_pkg::CFG_TIMEOUT_MS:        cfg_timeout = value;
            ppr_pkg::CFG_PROBE_SOURCE_PORT: cfg_src_port = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic udp, input logic [15:0] timeout,
                             input logic [15:0] src_port);
        write_register(ppr_pkg::CFG_PROBE_IS_UDP, {15'd0, udp});
        write_register(ppr_pkg::CFG_TIMEOUT_MS, timeout);
        write_register(ppr_pkg::CFG_PROBE_SOURCE_PORT, src_port);
    endtask

    task automatic put_byte(input int idx, input logic [7:0] b);
        if (idx < frame_buf.size())
            frame_buf[idx] = b;
    endtask

    task automatic put_word(input int idx, input logic [15:0] w);
        put_byte(idx, w[15:8]);
        put_byte(idx + 1, w[7:0]);
    endtask

    // A frame starts as random bytes; the IPv4 version/IHL byte and the
    // protocol byte are then placed where the parser looks for them.
    task automatic start_frame(input logic [3:0] ihl, input logic [7:0] proto,
                               input int len);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
        put_byte(LINK_BYTES, {4'h4, ihl});
        put_byte(LINK_BYTES + 9, proto);
    endtask

    task automatic pad_frame(input int len);
        while (frame_buf.size() < len)
            frame_buf.push_back(8'($urandom));
    endtask

    task automatic build_tcp(input logic [15:0] src, input logic [7:0] flags,
                             input logic [3:0] ihl);
        int tr;
        tr = LINK_BYTES + 4 * int'(ihl);
        start_frame(ihl, ppr_pkg::PROTO_TCP, tr + 20 + $urandom_range(0, 8));
        put_word(tr, src);
        put_byte(tr + 13, flags);
    endtask

    task automatic build_udp(input logic [15:0] src, input logic [3:0] ihl);
        int tr;
        tr = LINK_BYTES + 4 * int'(ihl);
        start_frame(ihl, ppr_pkg::PROTO_UDP, tr + 8 + $urandom_range(0, 16));
        put_word(tr, src);
    endtask

    task automatic build_icmp(input logic [7:0] icmp_type, input logic [7:0] icmp_code,
                              input logic [3:0] inner_ihl, input logic [7:0] quoted_proto,
                              input logic [15:0] quoted_src, input logic [15:0] quoted_dst,
                              input logic [3:0] ihl);
        int tr;
        int em;
        int eu;
        tr = LINK_BYTES + 4 * int'(ihl);
        em = tr + 8;
        eu = em + 4 * int'(inner_ihl);
        start_frame(ihl, ppr_pkg::PROTO_ICMP, eu + 4 + $urandom_range(0, 8));
        put_byte(tr, icmp_type);
        put_byte(tr + 1, icmp_code);
        put_byte(em, {4'h4, inner_ihl});
        put_byte(em + 9, quoted_proto);
        put_word(eu, quoted_src);
        put_word(eu + 2, quoted_dst);
    endtask

    // Sends the assembled frame, cut down to keep bytes when keep is not zero.
    task automatic send_frame(input int keep);
        int k;
        if (keep > 0)
            while (frame_buf.size() > keep)
                void'(frame_buf.pop_back());
        for (k = 0; k < frame_buf.size(); k++)
            queue_request(ppr_pkg::OP_BYTE, frame_buf[k], k == frame_buf.size() - 1,
                          16'($urandom));
    endtask

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 20)
            return 16'hFFFF;
        if (r < 35)
            return 16'($urandom_range(1, 1024));
        return 16'($urandom);
    endfunction

    // Mostly a standard 20-byte header, sometimes options, rarely nonsense.
    function automatic logic [3:0] pick_ihl();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 4'd5;
        if (r < 92)
            return 4'($urandom_range(6, 15));
        return 4'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] pick_flags();
        case ($urandom_range(0, 5))
            0: return ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK;
            1: return ppr_pkg::FLAG_RST;
            2: return ppr_pkg::FLAG_RST | ppr_pkg::FLAG_ACK;
            3: return ppr_pkg::FLAG_SYN;
            4: return ppr_pkg::FLAG_ACK;
            default: return 8'($urandom);
        endcase
    endfunction

    // A plausible reply to the probe on the given port: the expected kind
    // for the configured probe type mostly, with one field or another
    // disturbed now and then so that near misses are exercised too.
    task automatic queue_reply_frame(input logic [15:0] port);
        logic [3:0]  ihl;
        logic [15:0] src;
        int          r;
        int          keep;
        ihl = pick_ihl();
        src = ($urandom_range(0, 3) != 0) ? port : 16'($urandom);
        r = $urandom_range(0, 99);
        if (cfg_udp_probe)
            r = (r < 40) ? 1 : (r < 85) ? 2 : 0;
        else
            r = (r < 80) ? 0 : (r < 90) ? 1 : 2;
        case (r)
            0: build_tcp(src, pick_flags(), ihl);
            1: build_udp(src, ihl);
            default: build_icmp(($urandom_range(0, 9) != 0) ? 8'd3 : 8'($urandom),
                                ($urandom_range(0, 6) != 0) ? 8'd3 : 8'($urandom_range(0, 15)),
                                pick_ihl(),
                                ($urandom_range(0, 6) != 0) ? ppr_pkg::PROTO_UDP
                                                            : 8'($urandom),
                                ($urandom_range(0, 6) != 0) ? cfg_src_port : 16'($urandom),
                                ($urandom_range(0, 6) != 0) ? port : 16'($urandom),
                                ihl);
        endcase
        keep = ($urandom_range(0, 99) < 8) ? $urandom_range(1, frame_buf.size()) : 0;
        send_frame(keep);
    endtask

    task automatic queue_noise_frame();
        frame_buf.delete();
        repeat ($urandom_range(1, 80)) frame_buf.push_back(8'($urandom));
        send_frame(0);
    endtask

    // One armed wait: a start request followed by a few frames, ticks,
    // capture errors or restarts. Occasionally some noise precedes the start
    // so that the idle state sees ticks, errors and frames as well.
    task automatic queue_probe_exchange();
        logic [15:0] port;
        int          events;
        int          k;
        int          r;
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 2))
                0: queue_tick();
                1: queue_capture_error();
                default: queue_noise_frame();
            endcase
        end
        port = pick_port();
        queue_start(port);
        events = $urandom_range(1, 6);
        for (k = 0; k < events; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_reply_frame(port);
            else if (r < 75)
                queue_tick();
            else if (r < 80)
                queue_capture_error();
            else if (r < 85)
            begin
                port = pick_port();
                queue_start(port);
            end
            else
                queue_noise_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        int          phase;
        int          goal;
        int          k;
        logic [15:0] timeout;
        logic [15:0] src_port;

        cfg_udp_probe = ppr_pkg::RESET_PROBE_IS_UDP;
        cfg_timeout = ppr_pkg::RESET_TIMEOUT_MS;
        cfg_src_port = ppr_pkg::RESET_PROBE_SOURCE_PORT;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset configuration (TCP probes).
        // While idle, a tick and a capture error are ignored and even a
        // matching reply gives no verdict.
        queue_tick();
        queue_capture_error();
        build_tcp(16'd0, ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK, 4'd5);
        send_frame(0);
        // SYN+ACK from the lowest port: open.
        queue_start(16'd0);
        build_tcp(16'd0, ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK, 4'd5);
        send_frame(0);
        // A reply from the wrong port is passed over, then RST: closed.
        queue_start(16'hFFFF);
        build_tcp(16'hFFFE, ppr_pkg::FLAG_RST, 4'd5);
        send_frame(0);
        build_tcp(16'hFFFF, ppr_pkg::FLAG_RST | ppr_pkg::FLAG_ACK, 4'd5);
        send_frame(0);
        // A bare ACK is an answer, but neither open nor closed.
        queue_start(16'd80);
        build_tcp(16'd80, ppr_pkg::FLAG_ACK, 4'd5);
        send_frame(0);
        // All flags set with maximum header options: SYN+ACK wins over RST.
        queue_start(16'd443);
        build_tcp(16'd443, 8'hFF, 4'd15);
        send_frame(0);
        // A restart moves the wait to a new port; the old port's reply no
        // longer counts, and the capture error ends the wait.
        queue_start(16'd22);
        queue_start(16'd23);
        build_tcp(16'd22, ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK, 4'd5);
        send_frame(0);
        queue_capture_error();
        // Frame cut off before the flags byte: the flags stay zero.
        queue_start(16'd25);
        build_tcp(16'd25, ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK, 4'd5);
        send_frame(LINK_BYTES + 20 + 2);
        // Nonsense header lengths that make fields overlap.
        queue_start(16'h1234);
        build_tcp(16'h1234, ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK, 4'd2);
        send_frame(0);
        build_tcp(16'h1234, ppr_pkg::FLAG_RST, 4'd0);
        send_frame(0);
        queue_capture_error();
        wait_idle();

        // UDP probes with a short timeout.
        configure(1'b1, 16'd2, ppr_pkg::RESET_PROBE_SOURCE_PORT);
        queue_start(16'd53);
        build_udp(16'd53, 4'd5);
        send_frame(0);
        queue_start(16'd161);
        build_icmp(8'd3, 8'd3, 4'd5, ppr_pkg::PROTO_UDP, ppr_pkg::RESET_PROBE_SOURCE_PORT,
                   16'd161, 4'd5);
        send_frame(0);
        // Near misses in the quoted header and in the ICMP code, then the timeout fires.
        queue_start(16'd161);
        build_icmp(8'd3, 8'd3, 4'd5, ppr_pkg::PROTO_UDP, ppr_pkg::RESET_PROBE_SOURCE_PORT,
                   16'd162, 4'd5);
        send_frame(0);
        build_icmp(8'd3, 8'd1, 4'd5, ppr_pkg::PROTO_UDP, ppr_pkg::RESET_PROBE_SOURCE_PORT,
                   16'd161, 4'd5);
        send_frame(0);
        queue_tick();
        queue_tick();
        queue_tick();
        wait_idle();

        // A long capture well past every header field; the reply fields sit
        // at the front, so it still decides open.
        write_register(ppr_pkg::CFG_PROBE_IS_UDP, 16'd0);
        queue_start(16'd8080);
        build_tcp(16'd8080, ppr_pkg::FLAG_SYN | ppr_pkg::FLAG_ACK, 4'd5);
        pad_frame(300);
        send_frame(0);
        wait_idle();

        // Random phases, each under its own configuration and idling mix.
        phase = 0;
        while (requests_queued < REQUEST_BUDGET || phase < 2)
        begin
            case (phase % 5)
                0: timeout = 16'hFFFF;
                1: timeout = 16'd1;
                4: timeout = 16'($urandom_range(1, 3000));
                default: timeout = 16'($urandom_range(1, 12));
            endcase
            case (phase % 4)
                0: src_port = 16'd0;
                1: src_port = 16'hFFFF;
                2: src_port = ppr_pkg::RESET_PROBE_SOURCE_PORT;
                default: src_port = 16'($urandom);
            endcase
            configure(1'(phase % 2), timeout, src_port);
            source_idling = ($urandom_range(0, 3) != 0);
            sink_idling = ($urandom_range(0, 3) != 0);
            if (phase == 1)
            begin
                // The receiver holds off for a long stretch while a dense
                // run of verdict-producing requests keeps arriving, so the
                // block fills up and pushes back on its input.
                source_idling = 1'b0;
                long_stalls_asked++;
                for (k = 0; k < 30; k++)
                begin
                    queue_start(pick_port());
                    if (k % 2 == 0)
                        queue_capture_error();
                    else
                        queue_tick();
                end
            end
            goal = requests_queued + 250;
            while (requests_queued < goal)
                queue_probe_exchange();
            // The sender pauses here until every verdict has come back.
            wait_idle();
            phase++;
        end

        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
